// ----- rtl/mexp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the modular exponentiation block: field widths, the reset value
// of the modulus and the request type of the shared multiply-reduce unit.
// Depends on nothing.
package mexp_pkg;

  localparam int unsigned MOD_W    = 32;          // modulus and residue width
  localparam int unsigned FIELD_W  = 63;          // base and exponent width
  localparam int unsigned PROD_W   = 2 * MOD_W;   // full product width
  localparam int unsigned DIV_W    = MOD_W + 1;   // divisor width, holds 2^32
  localparam int unsigned RED_BITS = 4;           // quotient bits per cycle
  localparam int unsigned RED_STEPS = PROD_W / RED_BITS;
  localparam int unsigned RED_CNT_W = $clog2(RED_STEPS);

  localparam logic [MOD_W-1:0] MODULUS_RESET = 32'd1000000007;

  // Request to the multiply-reduce unit: start pulses for one cycle; mul
  // selects a product of the two operands, otherwise the wide operand is
  // reduced as it is.
  typedef struct packed {
    logic start;
    logic mul;
  } mm_req_t;

endpackage

// ----- rtl/mexp_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the modular exponentiation block: valid, ready, base and
// exponent. Depends on mexp_pkg.
interface mexp_in_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::FIELD_W-1:0]  base;
  logic [mexp_pkg::FIELD_W-1:0]  exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

// ----- rtl/mexp_out_if.sv -----
`timescale 1ns / 1ps
// Output channel of the modular exponentiation block: valid, ready and the
// result power_mod. Depends on mexp_pkg.
interface mexp_out_if;
  logic                        valid;
  logic                        ready;
  logic [mexp_pkg::MOD_W-1:0]  power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

// ----- rtl/mexp_modmul.sv -----
`timescale 1ns / 1ps
// Shared multiply-reduce unit: one 32x32 multiply, then a restoring
// remainder over the 64-bit product (or over x_i as it is, without the
// multiply), RED_BITS quotient bits per cycle. Depends on mexp_pkg.
module mexp_modmul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mexp_pkg::mm_req_t             req_i,
  input  logic [mexp_pkg::MOD_W-1:0]    a_i,
  input  logic [mexp_pkg::MOD_W-1:0]    b_i,
  input  logic [mexp_pkg::PROD_W-1:0]   x_i,
  input  logic [mexp_pkg::DIV_W-1:0]    div_i,
  output logic                          done_o,
  output logic [mexp_pkg::MOD_W-1:0]    res_o
);
  import mexp_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_RED} unit_state_e;

  unit_state_e          state_q;
  logic [MOD_W-1:0]     a_q, b_q;
  logic [PROD_W-1:0]    num_q, num_d;
  logic [MOD_W-1:0]     rem_q, rem_d;
  logic [RED_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [PROD_W-1:0]    prod_w;

  assign prod_w = a_q * b_q;

  // RED_BITS steps of shift-in, compare and subtract. The remainder stays
  // below the divisor, so it fits MOD_W bits even for a divisor of 2^32.
  always_comb begin
    logic [DIV_W-1:0] trial;
    rem_d = rem_q;
    num_d = num_q;
    trial = '0;
    for (int k = 0; k < RED_BITS; k++) begin
      trial = {rem_d, num_d[PROD_W-1]};
      num_d = num_d << 1;
      if (trial >= div_i) begin
        trial = trial - div_i;
      end
      rem_d = trial[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      num_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == U_RED) && (cnt_q == RED_CNT_W'(RED_STEPS - 1));
      case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            if (req_i.mul) begin
              a_q     <= a_i;
              b_q     <= b_i;
              state_q <= U_MUL;
            end else begin
              num_q   <= x_i;
              rem_q   <= '0;
              cnt_q   <= '0;
              state_q <= U_RED;
            end
          end
        end
        U_MUL: begin
          num_q   <= prod_w;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= U_RED;
        end
        U_RED: begin
          num_q <= num_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + RED_CNT_W'(1);
          if (cnt_q == RED_CNT_W'(RED_STEPS - 1)) begin
            state_q <= U_IDLE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = rem_q;

endmodule

// ----- rtl/modular_exponentiation.sv -----
`timescale 1ns / 1ps
// Top level of the modular exponentiation block: sequencer, modulus register
// and output register around the shared multiply-reduce unit.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and mexp_modmul.

// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// One beat on the input channel carries a base and an exponent; one beat on
// the output channel returns power_mod. The modulus is a 32-bit register
// written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the block is idle, as the block itself does not enforce this. It resets to
// 1000000007, and a modulus of zero acts as 2^32 (the low 32 bits are kept).
// An exponent of zero returns 1 for every modulus. Only the low EXP_BITS bits
// of the exponent are used. All arithmetic runs through one shared unit that
// multiplies two 32-bit residues and then reduces the 64-bit product 4
// quotient bits at a time. An item costs one base reduction, one squaring
// for each exponent bit below the highest set one, and one multiplication
// for each set bit. The input is not ready while an item is in progress; a
// finished result waits in the output register, and the next item is
// accepted meanwhile.
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mexp_pkg::MOD_W-1:0]    cfg_wdata_i,
  mexp_in_if.sink                       in_i,
  mexp_out_if.source                    out_o
);
  import mexp_pkg::*;

  // Mask that keeps the exponent bits the block honors.
  localparam logic [FIELD_W-1:0] EXP_MASK =
    FIELD_W'((64'd1 << EXP_BITS) - 64'd1);

  typedef enum logic [2:0] {S_IDLE, S_BASE, S_STEP, S_MUL, S_SQ} seq_state_e;

  seq_state_e         state_q;
  logic [MOD_W-1:0]   modulus_q;
  logic [FIELD_W-1:0] base_q;
  logic [FIELD_W-1:0] exp_q;
  logic [MOD_W-1:0]   acc_q;     // running result
  logic [MOD_W-1:0]   sq_q;      // current power of the base
  logic               sel_acc_q; // first operand: running result or power
  mm_req_t            req_q;
  logic               out_vld_q;
  logic [MOD_W-1:0]   power_q;

  logic               mm_done;
  logic [MOD_W-1:0]   mm_res;
  logic [DIV_W-1:0]   divisor;
  logic [MOD_W-1:0]   op_a;
  logic               item_done;

  // A modulus of zero stands for 2^32, which the 33-bit divisor holds.
  assign divisor = {(modulus_q == '0), modulus_q};
  assign op_a    = sel_acc_q ? acc_q : sq_q;

  // The item is finished and its result can move into the output register,
  // which is either empty or being emptied in this cycle.
  assign item_done = (state_q == S_STEP) && (exp_q == '0) &&
                     (!out_vld_q || out_o.ready);

  mexp_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .a_i    (op_a),
    .b_i    (sq_q),
    .x_i    ({{(PROD_W - FIELD_W){1'b0}}, base_q}),
    .div_i  (divisor),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  // Sequencer. Each exponent bit is consumed from the bottom of exp_q: a set
  // bit first folds the current power into the running result, then the
  // power is squared and the exponent shifted. The loop ends as soon as no
  // set bit remains, and the squaring after the last set bit is skipped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      modulus_q <= MODULUS_RESET;
      base_q    <= '0;
      exp_q     <= '0;
      acc_q     <= '0;
      sq_q      <= '0;
      sel_acc_q <= 1'b0;
      req_q     <= '0;
      out_vld_q <= 1'b0;
      power_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
      if (item_done) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            base_q    <= in_i.base;
            exp_q     <= in_i.exponent & EXP_MASK;
            acc_q     <= MOD_W'(1);
            req_q     <= '{start: 1'b1, mul: 1'b0};
            state_q   <= S_BASE;
          end else begin
            req_q     <= '0;
          end
        end
        S_BASE: begin
          req_q <= '0;
          if (mm_done) begin
            sq_q    <= mm_res;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (exp_q == '0) begin
            // Done; hand over once the output register is free.
            req_q <= '0;
            if (item_done) begin
              power_q <= acc_q;
              state_q <= S_IDLE;
            end
          end else if (exp_q[0]) begin
            sel_acc_q <= 1'b1;
            req_q     <= '{start: 1'b1, mul: 1'b1};
            state_q   <= S_MUL;
          end else begin
            sel_acc_q <= 1'b0;
            req_q     <= '{start: 1'b1, mul: 1'b1};
            state_q   <= S_SQ;
          end
        end
        S_MUL: begin
          if (mm_done) begin
            acc_q <= mm_res;
            if (exp_q[FIELD_W-1:1] == '0) begin
              req_q   <= '0;
              exp_q   <= '0;
              state_q <= S_STEP;
            end else begin
              sel_acc_q <= 1'b0;
              req_q     <= '{start: 1'b1, mul: 1'b1};
              state_q   <= S_SQ;
            end
          end else begin
            req_q <= '0;
          end
        end
        S_SQ: begin
          req_q <= '0;
          if (mm_done) begin
            sq_q    <= mm_res;
            exp_q   <= exp_q >> 1;
            state_q <= S_STEP;
          end
        end
        default: begin
          req_q   <= '0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_vld_q;
  assign out_o.power_mod = power_q;

  // An accepted beat leaves the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input still ready after a beat was accepted");

  // The shared unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == S_BASE || state_q == S_MUL || state_q == S_SQ))
    else $error("multiply-reduce result arrived with no operation pending");

  // A new result only appears when the sequencer has finished an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(state_q == S_STEP) && state_q == S_IDLE))
    else $error("result raised outside the end of an item");

  // Requests to the shared unit are single-cycle pulses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.start |=> !req_q.start)
    else $error("multiply-reduce request held for more than one cycle");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation: a directed table, then
// random phases under several moduli, each result checked against a typed or
// predicted value. Depends on mexp_pkg, mexp_in_if, mexp_out_if and the DUT.
module tb_top;

  import mexp_pkg::*;

  localparam int unsigned EXP_BITS  = 63;
  localparam int unsigned NUM_DIR   = 23;
  localparam int unsigned NUM_PHASE = 9;
  localparam int unsigned PHASE_ITEMS = 81;
  localparam int unsigned MAX_SHOWN = 10;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  // One directed row: an optional modulus write before the item, the item, and
  // a typed result where one can be given by hand.
  typedef struct packed {
    logic               set_mod;
    logic [MOD_W-1:0]   modulus;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] expo;
    logic               typed;
    logic [MOD_W-1:0]   result;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [MOD_W-1:0] cfg_wdata_i;

  mexp_in_if  in_if ();
  mexp_out_if out_if ();

  modular_exponentiation #(.EXP_BITS(EXP_BITS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Results expected from the block, oldest first.
  logic [MOD_W-1:0] pending_powers [$];
  logic [MOD_W-1:0] model_modulus;
  int unsigned      fail_count;
  logic             quiet;   // when set, neither side idles

  dir_row_t dir_rows [NUM_DIR] = '{
    // Exponent zero gives one, whatever the base.
    '{1'b0, 32'd0, 63'd5, 63'd0, 1'b1, 32'd1},
    '{1'b0, 32'd0, 63'd0, 63'd0, 1'b1, 32'd1},
    '{1'b0, 32'd0, 63'd0, 63'd5, 1'b1, 32'd0},
    '{1'b0, 32'd0, 63'd2, 63'd10, 1'b1, 32'd1024},
    '{1'b0, 32'd0, 63'd1, FIELD_MAX, 1'b1, 32'd1},
    '{1'b0, 32'd0, FIELD_MAX, 63'd1, 1'b0, 32'd0},
    '{1'b0, 32'd0, FIELD_MAX, FIELD_MAX, 1'b0, 32'd0},
    // A base equal to the modulus reduces to zero, one above it to one.
    '{1'b0, 32'd0, 63'd1000000007, 63'd3, 1'b1, 32'd0},
    '{1'b0, 32'd0, 63'd1000000008, FIELD_MAX, 1'b1, 32'd1},
    // Modulus one: zero for any nonzero exponent, one for exponent zero.
    '{1'b1, 32'd1, 63'd7, 63'd0, 1'b1, 32'd1},
    '{1'b0, 32'd0, FIELD_MAX, FIELD_MAX, 1'b1, 32'd0},
    '{1'b0, 32'd0, 63'd12345, 63'd1, 1'b1, 32'd0},
    // Modulus zero acts as two to the 32nd.
    '{1'b1, 32'd0, 63'd2, 63'd31, 1'b1, 32'h8000_0000},
    '{1'b0, 32'd0, 63'd2, 63'd32, 1'b1, 32'd0},
    '{1'b0, 32'd0, FIELD_MAX, 63'd1, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, 32'd0, 63'd3, FIELD_MAX, 1'b0, 32'd0},
    // Largest modulus: minus one squared is one.
    '{1'b1, 32'hFFFF_FFFF, 63'hFFFF_FFFF, 63'd5, 1'b1, 32'd0},
    '{1'b0, 32'd0, 63'hFFFF_FFFE, 63'd2, 1'b1, 32'd1},
    '{1'b0, 32'd0, FIELD_MAX, FIELD_MAX, 1'b0, 32'd0},
    '{1'b1, 32'd2, 63'd3, 63'd5, 1'b1, 32'd1},
    '{1'b0, 32'd0, 63'd4, 63'd7, 1'b1, 32'd0},
    '{1'b1, 32'd13, 63'd2, 63'd12, 1'b1, 32'd1},
    '{1'b0, 32'd0, 63'd2, 63'h4000_0000_0000_0000, 1'b0, 32'd0}
  };

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Reduction as the block does it: modulus zero keeps the low 32 bits.
  function automatic logic [63:0] reduce_mod(logic [63:0] x, logic [MOD_W-1:0] m);
    if (m == '0) begin
      return {32'd0, x[31:0]};
    end
    return x % {32'd0, m};
  endfunction

  // Right-to-left square-and-multiply over the low EXP_BITS exponent bits.
  function automatic logic [MOD_W-1:0] predict_power(logic [FIELD_W-1:0] base,
                                                     logic [FIELD_W-1:0] expo,
                                                     logic [MOD_W-1:0]   m);
    logic [63:0] b;
    logic [63:0] acc;
    b = reduce_mod({1'b0, base}, m);
    acc = 64'd1;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (expo[i]) begin
        acc = reduce_mod(acc * b, m);
      end
      b = reduce_mod(b * b, m);
    end
    return acc[MOD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[FIELD_W-1:0];
  endfunction

  // Idle length: mostly none or short, now and then long enough to span a
  // good part of one computation.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 25);
    return $urandom_range(40, 300);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Drives one beat of base and exponent after a random gap and waits until
  // it is taken. The expected power is queued at the accepting edge, using a
  // typed value when one is given.
  task automatic send_operands(logic [FIELD_W-1:0] base, logic [FIELD_W-1:0] expo,
                               logic typed, logic [MOD_W-1:0] typed_result);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid    <= 1'b1;
    in_if.base     <= base;
    in_if.exponent <= expo;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (typed) begin
      pending_powers.push_back(typed_result);
    end else begin
      pending_powers.push_back(predict_power(base, expo, model_modulus));
    end
  endtask

  // Lowers valid at the next falling edge, so the last beat is not taken
  // twice, and waits until every queued result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending_powers.size() == 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_modulus(logic [MOD_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_modulus = value;
  endtask

  // Random base: edge values, values around multiples of the modulus, and
  // small values and plain random ones of 32 and 63 bits.
  function automatic logic [FIELD_W-1:0] pick_base(logic [MOD_W-1:0] m);
    logic [63:0] span;
    logic [63:0] v;
    span = (m == '0) ? 64'h1_0000_0000 : {32'd0, m};
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = 64'd1;
      2: v = span * 64'($urandom_range(1, 5)) - 64'd1;
      3: v = span * 64'($urandom_range(1, 5)) + 64'($urandom_range(0, 1));
      4: v = {32'd0, $urandom()};
      5: v = 64'($urandom_range(2, 1000));
      default: v = {1'b0, rand_field()};
    endcase
    return v[FIELD_W-1:0];
  endfunction

  // Random exponent: some zero, mostly short to keep the run brief, and a
  // tenth of 33 up to FIELD_W bits, so that every exponent bit toggles.
  function automatic logic [FIELD_W-1:0] pick_exponent();
    int unsigned roll;
    int unsigned len;
    logic [FIELD_W-1:0] e;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return '0;
    end
    if (roll < 75) len = $urandom_range(1, 12);
    else if (roll < 90) len = $urandom_range(13, 32);
    else len = $urandom_range(33, FIELD_W);
    e = rand_field() >> (FIELD_W - len);
    e[len-1] = 1'b1;
    return e;
  endfunction

  // Result side: ready stalls at random and every beat is checked against the
  // oldest expectation.
  initial begin : result_sink
    int unsigned stall;
    logic [MOD_W-1:0] want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      if (pending_powers.size() == 0) begin
        note_failure($sformatf("unexpected result beat, power_mod %h", out_if.power_mod));
      end else begin
        want = pending_powers.pop_front();
        if (out_if.power_mod !== want) begin
          note_failure($sformatf("power_mod mismatch: expected %h, got %h",
                                 want, out_if.power_mod));
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases, each under its
  // own modulus, with one full drain inside every phase.
  initial begin : stimulus
    logic [MOD_W-1:0] phase_mod [NUM_PHASE];
    int unsigned pause_at;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.base     = '0;
    in_if.exponent = '0;
    out_if.ready   = 1'b0;
    quiet          = 1'b0;
    fail_count     = 0;
    model_modulus  = MODULUS_RESET;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NUM_DIR; r++) begin
      if (dir_rows[r].set_mod) begin
        set_modulus(dir_rows[r].modulus);
      end
      send_operands(dir_rows[r].base, dir_rows[r].expo, dir_rows[r].typed,
                    dir_rows[r].result);
    end

    phase_mod[0] = $urandom();
    phase_mod[1] = MODULUS_RESET;
    phase_mod[2] = '0;
    phase_mod[3] = $urandom_range(3, 65535);
    phase_mod[4] = 32'd1;
    phase_mod[5] = 32'hFFFF_FFFF;
    phase_mod[6] = 32'd2;
    phase_mod[7] = 32'h8000_0000 | $urandom();
    phase_mod[8] = $urandom();

    for (int p = 0; p < NUM_PHASE; p++) begin
      set_modulus(phase_mod[p]);
      // One phase runs back to back with no idling on either side.
      quiet = (p == 3);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) begin
          drain();
        end
        send_operands(pick_base(model_modulus), pick_exponent(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    drain();
    repeat (100) @(posedge clk_i);
    if (pending_powers.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_powers.size()));
    end
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #300_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mexp_pkg.sv
rtl/mexp_in_if.sv
rtl/mexp_out_if.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation.sv
tb/tb_top.sv
